// ----- rtl/tdps_pkg.sv -----
// Shared types and constants for the top-k dot product search block.
// No dependencies; every other file in rtl imports this package.
package tdps_pkg;

    localparam int DEF_MAX_DOMAINS  = 256;
    localparam int DEF_MAX_FEATURES = 64;
    localparam int DEF_MAX_TOPK     = 16;

    localparam int FEAT_W     = 16;
    localparam int PROD_W     = 32;
    localparam int SCORE_W    = 38;
    localparam int IDX_W      = 8;
    localparam int RANK_W     = 4;
    localparam int FIDX_W     = 6;
    localparam int DIDX_W     = 8;
    localparam int TOPK_REG_W = 5;
    localparam int DCNT_REG_W = 9;
    localparam int FCNT_REG_W = 7;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [TOPK_REG_W-1:0] RST_TOP_K        = 5'd16;
    localparam logic [DCNT_REG_W-1:0] RST_DOMAIN_COUNT = 9'd256;
    localparam logic [FCNT_REG_W-1:0] RST_FEATURE_COUNT = 7'd64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int DRAIN_CYCLES = 3;

    typedef enum logic [1:0] {
        REG_TOP_K         = 2'd0,
        REG_DOMAIN_COUNT  = 2'd1,
        REG_FEATURE_COUNT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef struct packed {
        logic clear;
        logic emit;
        logic emit_last;
    } t_seq_ctl;

endpackage

// ----- rtl/tdps_ram.sv -----
// Single-port-write, single-port-read memory with registered read data.
// Depends on tdps_pkg for the word width.
module tdps_ram #(
    parameter int  DEPTH = tdps_pkg::DEF_MAX_FEATURES,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tdps_pkg::FEAT_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tdps_pkg::FEAT_W-1:0] o_rdata
);
    import tdps_pkg::*;

    logic [FEAT_W-1:0] r_mem [DEPTH];
    logic [FEAT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tdps_mac.sv -----
// Shared multiply-accumulate unit: one product per cycle, saturated score per domain.
// Depends on tdps_pkg for widths and the control word type.
module tdps_mac #(
    parameter int MAX_FEATURES = tdps_pkg::DEF_MAX_FEATURES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdps_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [tdps_pkg::FEAT_W-1:0]  i_dom_data,
    input  logic signed [tdps_pkg::FEAT_W-1:0]  i_qry_data,
    output logic                                o_score_v,
    output logic signed [tdps_pkg::SCORE_W-1:0] o_score
);
    import tdps_pkg::*;

    localparam int ACC_W = SCORE_W + $clog2(MAX_FEATURES);

    t_mac_ctl                  r_tag1;
    t_mac_ctl                  r_tag2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_score_v;
    logic signed [SCORE_W-1:0] r_score;

    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   n_acc;
    logic [ACC_W-SCORE_W:0]    acc_hi;
    logic                      acc_fits;
    logic signed [SCORE_W-1:0] n_score;

    always_comb begin
        prod_ext = ACC_W'(r_prod);
        n_acc    = r_tag2.first ? prod_ext : r_acc + prod_ext;
        acc_hi   = n_acc[ACC_W-1:SCORE_W-1];
        acc_fits = (&acc_hi) | ~(|acc_hi);
        if (acc_fits) begin
            n_score = n_acc[SCORE_W-1:0];
        end else if (n_acc[ACC_W-1]) begin
            n_score = {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            n_score = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1    <= '0;
            r_tag2    <= '0;
            r_score_v <= 1'b0;
        end else begin
            r_tag1    <= i_ctl;
            r_tag2    <= r_tag1;
            r_score_v <= r_tag2.valid & r_tag2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_dom_data * i_qry_data;
        if (r_tag2.valid) begin
            r_acc <= n_acc;
        end
        if (r_tag2.valid && r_tag2.last) begin
            r_score <= n_score;
        end
    end

    assign o_score_v = r_score_v;
    assign o_score   = r_score;

endmodule

// ----- rtl/tdps_topk.sv -----
// Sorted list of the best scores with combinational insertion into registered slots, and the result word register.
// Depends on tdps_pkg for widths and the sequencer control type.
module tdps_topk #(
    parameter int  MAX_DOMAINS = tdps_pkg::DEF_MAX_DOMAINS,
    parameter int  MAX_TOPK    = tdps_pkg::DEF_MAX_TOPK,
    localparam int K_W         = $clog2(MAX_TOPK + 1),
    localparam int TK_IW       = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdps_pkg::t_seq_ctl                  i_seq_ctl,
    input  logic [K_W-1:0]                      i_k,
    input  logic [TK_IW-1:0]                    i_rank,
    input  logic                                i_score_v,
    input  logic signed [tdps_pkg::SCORE_W-1:0] i_score,
    output logic                                o_valid,
    output logic [tdps_pkg::RANK_W-1:0]         o_rank,
    output logic [tdps_pkg::IDX_W-1:0]          o_match_index,
    output logic signed [tdps_pkg::SCORE_W-1:0] o_score,
    output logic                                o_last
);
    import tdps_pkg::*;

    localparam int DCNT_W = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;

    logic signed [SCORE_W-1:0] r_best_score [MAX_TOPK];
    logic [IDX_W-1:0]          r_best_idx   [MAX_TOPK];
    logic signed [SCORE_W-1:0] n_best_score [MAX_TOPK];
    logic [IDX_W-1:0]          n_best_idx   [MAX_TOPK];
    logic [K_W-1:0]            r_filled;
    logic [DCNT_W-1:0]         r_dom_cnt;

    logic                      r_valid;
    logic [RANK_W-1:0]         r_rank;
    logic [IDX_W-1:0]          r_match_index;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_last;

    logic [MAX_TOPK-1:0]       gt;
    logic [MAX_TOPK-1:0]       ins;
    logic                      reject;
    logic [DCNT_W+IDX_W-1:0]   dom_ext;
    logic [IDX_W-1:0]          cur_idx;
    logic [TK_IW+RANK_W-1:0]   rank_ext;

    assign dom_ext  = {{IDX_W{1'b0}}, r_dom_cnt};
    assign cur_idx  = dom_ext[IDX_W-1:0];
    assign rank_ext = {{RANK_W{1'b0}}, i_rank};

    for (genvar g = 0; g < MAX_TOPK; g++) begin : g_slot
        assign gt[g]  = (K_W'(g) < r_filled) && (i_score > r_best_score[g]);
        assign ins[g] = (K_W'(g) >= r_filled) || gt[g];
        if (g == 0) begin : g_head
            assign n_best_score[g] = ins[g] ? i_score : r_best_score[g];
            assign n_best_idx[g]   = ins[g] ? cur_idx : r_best_idx[g];
        end else begin : g_body
            always_comb begin
                if (!ins[g]) begin
                    n_best_score[g] = r_best_score[g];
                    n_best_idx[g]   = r_best_idx[g];
                end else if (ins[g-1]) begin
                    n_best_score[g] = r_best_score[g-1];
                    n_best_idx[g]   = r_best_idx[g-1];
                end else begin
                    n_best_score[g] = i_score;
                    n_best_idx[g]   = cur_idx;
                end
            end
        end
    end

    assign reject = (r_filled == i_k) && !(|gt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled  <= '0;
            r_dom_cnt <= '0;
        end else if (i_seq_ctl.clear) begin
            r_filled  <= '0;
            r_dom_cnt <= '0;
        end else if (i_score_v) begin
            r_dom_cnt <= r_dom_cnt + DCNT_W'(1);
            if (r_filled != i_k) begin
                r_filled <= r_filled + K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_score_v && !reject && !i_seq_ctl.clear) begin
            r_best_score <= n_best_score;
            r_best_idx   <= n_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_seq_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seq_ctl.emit) begin
            r_rank        <= rank_ext[RANK_W-1:0];
            r_match_index <= r_best_idx[i_rank];
            r_score       <= r_best_score[i_rank];
            r_last        <= i_seq_ctl.emit_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_rank        = r_rank;
    assign o_match_index = r_match_index;
    assign o_score       = r_score;
    assign o_last        = r_last;

endmodule

// ----- rtl/tdps_seq.sv -----
// Search sequencer: walks domains and features, drains the MAC, then steps out the ranks.
// Depends on tdps_pkg for the state type and control word types.
module tdps_seq #(
    parameter int  MAX_DOMAINS  = tdps_pkg::DEF_MAX_DOMAINS,
    parameter int  MAX_FEATURES = tdps_pkg::DEF_MAX_FEATURES,
    parameter int  MAX_TOPK     = tdps_pkg::DEF_MAX_TOPK,
    localparam int ND_W  = $clog2(MAX_DOMAINS + 1),
    localparam int NF_W  = $clog2(MAX_FEATURES + 1),
    localparam int K_W   = $clog2(MAX_TOPK + 1),
    localparam int AW    = (MAX_DOMAINS * MAX_FEATURES > 1) ?
                           $clog2(MAX_DOMAINS * MAX_FEATURES) : 1,
    localparam int FI_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    localparam int TK_IW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [ND_W-1:0]    i_nd,
    input  logic [NF_W-1:0]    i_nf,
    input  logic [K_W-1:0]     i_k,
    output logic               o_busy,
    output logic [AW-1:0]      o_dom_raddr,
    output logic [FI_W-1:0]    o_qry_raddr,
    output tdps_pkg::t_mac_ctl o_mac_ctl,
    output tdps_pkg::t_seq_ctl o_seq_ctl,
    output logic [K_W-1:0]     o_k,
    output logic [TK_IW-1:0]   o_rank
);
    import tdps_pkg::*;

    t_state            r_state, n_state;
    logic [ND_W-1:0]   r_nd;
    logic [NF_W-1:0]   r_nf;
    logic [K_W-1:0]    r_k;
    logic [FI_W-1:0]   r_f, n_f;
    logic [ND_W-1:0]   r_d, n_d;
    logic [AW-1:0]     r_base, n_base;
    logic [1:0]        r_drain, n_drain;
    logic [TK_IW-1:0]  r_rank, n_rank;

    logic f_last;
    logic d_last;
    logic rank_last;

    assign f_last    = NF_W'(r_f) == (r_nf - NF_W'(1));
    assign d_last    = r_d == (r_nd - ND_W'(1));
    assign rank_last = K_W'(r_rank) == (r_k - K_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_f     <= '0;
            r_d     <= '0;
            r_base  <= '0;
            r_drain <= '0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_f     <= n_f;
            r_d     <= n_d;
            r_base  <= n_base;
            r_drain <= n_drain;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && r_state == ST_IDLE) begin
            r_nd <= i_nd;
            r_nf <= i_nf;
            r_k  <= i_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_f     = r_f;
        n_d     = r_d;
        n_base  = r_base;
        n_drain = r_drain;
        n_rank  = r_rank;

        o_mac_ctl = '0;
        o_seq_ctl = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    o_seq_ctl.clear = 1'b1;
                    n_state = ST_RUN;
                    n_f     = '0;
                    n_d     = '0;
                    n_base  = '0;
                    n_rank  = '0;
                end
            end
            ST_RUN: begin
                o_mac_ctl.valid = 1'b1;
                o_mac_ctl.first = (r_f == '0);
                o_mac_ctl.last  = f_last;
                if (f_last) begin
                    n_f    = '0;
                    n_base = r_base + AW'(MAX_FEATURES);
                    if (d_last) begin
                        n_state = ST_DRAIN;
                        n_drain = '0;
                    end else begin
                        n_d = r_d + ND_W'(1);
                    end
                end else begin
                    n_f = r_f + FI_W'(1);
                end
            end
            ST_DRAIN: begin
                if (r_drain == 2'(DRAIN_CYCLES - 1)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_drain = r_drain + 2'd1;
                end
            end
            ST_EMIT: begin
                o_seq_ctl.emit      = 1'b1;
                o_seq_ctl.emit_last = rank_last;
                n_rank = r_rank + TK_IW'(1);
                if (rank_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = r_state != ST_IDLE;
    assign o_dom_raddr = r_base + AW'(r_f);
    assign o_qry_raddr = r_f;
    assign o_k         = r_k;
    assign o_rank      = r_rank;

endmodule

// ----- rtl/topk_dot_product_search.sv -----
// Top-k inner product search. Loads and non-final query words can be accepted back to back.
// A final query word starts a search: busy while the sequencer walks, drains and emits;
// results appear one per cycle; the single multiply-accumulate unit reads one store word per cycle.
// Synchronous active-low reset restores register defaults and idles the sequencer;
// stores hold no reset. Results cannot be stalled.
module topk_dot_product_search #(
    parameter int MAX_DOMAINS  = tdps_pkg::DEF_MAX_DOMAINS,
    parameter int MAX_FEATURES = tdps_pkg::DEF_MAX_FEATURES,
    parameter int MAX_TOPK     = tdps_pkg::DEF_MAX_TOPK
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic [tdps_pkg::DIDX_W-1:0]         i_domain_index,
    input  logic [tdps_pkg::FIDX_W-1:0]         i_feature_index,
    input  logic signed [tdps_pkg::FEAT_W-1:0]  i_feature_value,
    output logic                                o_result_valid,
    output logic [tdps_pkg::RANK_W-1:0]         o_rank,
    output logic [tdps_pkg::IDX_W-1:0]          o_match_index,
    output logic signed [tdps_pkg::SCORE_W-1:0] o_score,
    output logic                                o_last_of_run,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tdps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tdps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tdps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tdps_pkg::*;

    localparam int ND_W  = $clog2(MAX_DOMAINS + 1);
    localparam int NF_W  = $clog2(MAX_FEATURES + 1);
    localparam int K_W   = $clog2(MAX_TOPK + 1);
    localparam int AW    = (MAX_DOMAINS * MAX_FEATURES > 1) ?
                           $clog2(MAX_DOMAINS * MAX_FEATURES) : 1;
    localparam int FI_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int TK_IW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;

    logic [TOPK_REG_W-1:0] r_top_k;
    logic [DCNT_REG_W-1:0] r_domain_count;
    logic [FCNT_REG_W-1:0] r_feature_count;

    logic     cfg_wr;
    t_reg_idx reg_idx;

    logic [31:0] raw_k, raw_nd, raw_nf;
    logic [31:0] k32, nd32, nf32, kc32;

    logic accept;
    logic fidx_ok;
    logic didx_ok;
    logic go;
    logic dom_we;
    logic qry_we;

    logic [AW-1:0]     dom_waddr;
    logic [AW-1:0]     dom_raddr;
    logic [FI_W-1:0]   qry_waddr;
    logic [FI_W-1:0]   qry_raddr;
    logic [FEAT_W-1:0] dom_rdata;
    logic [FEAT_W-1:0] qry_rdata;

    t_mac_ctl          mac_ctl;
    t_seq_ctl          seq_ctl;
    logic [K_W-1:0]    k_run;
    logic [TK_IW-1:0]  rank_run;
    logic              score_v;
    logic signed [SCORE_W-1:0] score;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_k         <= RST_TOP_K;
            r_domain_count  <= RST_DOMAIN_COUNT;
            r_feature_count <= RST_FEATURE_COUNT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TOP_K:         r_top_k         <= pwdata[TOPK_REG_W-1:0];
                REG_DOMAIN_COUNT:  r_domain_count  <= pwdata[DCNT_REG_W-1:0];
                REG_FEATURE_COUNT: r_feature_count <= pwdata[FCNT_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TOP_K:         prdata = APB_DATA_W'(r_top_k);
            REG_DOMAIN_COUNT:  prdata = APB_DATA_W'(r_domain_count);
            REG_FEATURE_COUNT: prdata = APB_DATA_W'(r_feature_count);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        raw_k  = 32'(r_top_k);
        raw_nd = 32'(r_domain_count);
        raw_nf = 32'(r_feature_count);
        k32  = (raw_k == 0) ? 32'd1 :
               (raw_k > 32'(MAX_TOPK)) ? 32'(MAX_TOPK) : raw_k;
        nd32 = (raw_nd == 0) ? 32'd1 :
               (raw_nd > 32'(MAX_DOMAINS)) ? 32'(MAX_DOMAINS) : raw_nd;
        nf32 = (raw_nf == 0) ? 32'd1 :
               (raw_nf > 32'(MAX_FEATURES)) ? 32'(MAX_FEATURES) : raw_nf;
        kc32 = (k32 > nd32) ? nd32 : k32;
    end

    assign accept  = start & ~busy;
    assign fidx_ok = 32'(i_feature_index) < 32'(MAX_FEATURES);
    assign didx_ok = 32'(i_domain_index) < 32'(MAX_DOMAINS);
    assign dom_we  = accept && fidx_ok && didx_ok && (i_opcode == OP_LOAD);
    assign qry_we  = accept && fidx_ok && (i_opcode == OP_QUERY);
    assign go      = qry_we && (32'(i_feature_index) == nf32 - 32'd1);

    assign dom_waddr = AW'(32'(i_domain_index) * 32'(MAX_FEATURES)
                           + 32'(i_feature_index));
    assign qry_waddr = FI_W'(i_feature_index);

    tdps_ram #(
        .DEPTH (MAX_DOMAINS * MAX_FEATURES)
    ) u_dom_store (
        .i_clk   (i_clk),
        .i_we    (dom_we),
        .i_waddr (dom_waddr),
        .i_wdata (i_feature_value),
        .i_raddr (dom_raddr),
        .o_rdata (dom_rdata)
    );

    tdps_ram #(
        .DEPTH (MAX_FEATURES)
    ) u_qry_buf (
        .i_clk   (i_clk),
        .i_we    (qry_we),
        .i_waddr (qry_waddr),
        .i_wdata (i_feature_value),
        .i_raddr (qry_raddr),
        .o_rdata (qry_rdata)
    );

    tdps_seq #(
        .MAX_DOMAINS  (MAX_DOMAINS),
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_TOPK     (MAX_TOPK)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_nd        (ND_W'(nd32)),
        .i_nf        (NF_W'(nf32)),
        .i_k         (K_W'(kc32)),
        .o_busy      (busy),
        .o_dom_raddr (dom_raddr),
        .o_qry_raddr (qry_raddr),
        .o_mac_ctl   (mac_ctl),
        .o_seq_ctl   (seq_ctl),
        .o_k         (k_run),
        .o_rank      (rank_run)
    );

    tdps_mac #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_dom_data ($signed(dom_rdata)),
        .i_qry_data ($signed(qry_rdata)),
        .o_score_v  (score_v),
        .o_score    (score)
    );

    tdps_topk #(
        .MAX_DOMAINS (MAX_DOMAINS),
        .MAX_TOPK    (MAX_TOPK)
    ) u_topk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seq_ctl     (seq_ctl),
        .i_k           (k_run),
        .i_rank        (rank_run),
        .i_score_v     (score_v),
        .i_score       (score),
        .o_valid       (o_result_valid),
        .o_rank        (o_rank),
        .o_match_index (o_match_index),
        .o_score       (o_score),
        .o_last        (o_last_of_run)
    );

endmodule
